// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files that check themselves
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lct_pkg.sv =====
// shared constants and types for the lru cache table
// no dependencies
`timescale 1ns / 1ps

package lct_pkg;

  localparam int DEPTH_DEF   = 8;
  localparam int KEY_W_DEF   = 32;
  localparam int VALUE_W_DEF = 32;

  // capacity register
  localparam int             CAP_W     = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd3;

  // apb side
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_CAPACITY = 1'b0;  // word index of the capacity register

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // update command from the select logic to the entry store
  typedef struct packed {
    logic apply;      // touch ranks this transfer
    logic write_kv;   // write key and value into the chosen slot
    logic inc_count;  // one more valid entry
  } lct_upd_t;

endpackage

// ===== rtl/lct_if.sv =====
// valid/ready channel interfaces for the lru cache table
// depends on lct_pkg
`timescale 1ns / 1ps

interface lct_in_if import lct_pkg::*; #(
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface lct_out_if import lct_pkg::*; #(
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  parameter int OCC_WIDTH   = $clog2(DEPTH_DEF + 1)
) ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] found_value;
  logic                   evicted;
  logic [KEY_WIDTH-1:0]   evicted_key;
  logic [OCC_WIDTH-1:0]   occupancy;

  modport source (output valid, hit, found_value, evicted, evicted_key, occupancy,
                  input ready);
  modport sink   (input valid, hit, found_value, evicted, evicted_key, occupancy,
                  output ready);
endinterface

// ===== rtl/lct_select.sv =====
// match, victim and slot selection for one request against the entry store
// depends on lct_pkg
`timescale 1ns / 1ps

module lct_select import lct_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int EW = (CW > CAP_W) ? CW : CAP_W
) (
  input  logic                   action,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [CAP_W-1:0]       capacity,
  input  logic [CW-1:0]          count,
  input  logic [KEY_WIDTH-1:0]   keys   [DEPTH],
  input  logic [VALUE_WIDTH-1:0] values [DEPTH],
  input  logic [RW-1:0]          ranks  [DEPTH],
  output lct_upd_t               upd,
  output logic [DEPTH-1:0]       slot_oh,
  output logic [CW-1:0]          limit,
  output logic                   hit,
  output logic [VALUE_WIDTH-1:0] found_value,
  output logic                   evicted,
  output logic [KEY_WIDTH-1:0]   evicted_key
);

  logic [EW-1:0]          cap_x;
  logic [EW-1:0]          eff_cap;
  logic                   full;
  logic [DEPTH-1:0]       valid;
  logic [DEPTH-1:0]       match;
  logic [DEPTH-1:0]       best_oh;
  logic [DEPTH-1:0]       lru_oh;
  logic [DEPTH-1:0]       ins_oh;
  logic [RW-1:0]          best_rank;
  logic [VALUE_WIDTH-1:0] best_value;
  logic [KEY_WIDTH-1:0]   lru_key;
  logic [CW-1:0]          lru_rank;

  // zero acts as one, above depth saturates
  always_comb begin
    cap_x = EW'(capacity);
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (cap_x > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_x;
    end
    full     = EW'(count) >= eff_cap;
    lru_rank = count - CW'(1);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i]  = CW'(i) < count;
      match[i]  = valid[i] && (keys[i] == key);
      lru_oh[i] = valid[i] && (CW'(ranks[i]) == lru_rank);
      ins_oh[i] = CW'(i) == count;
    end
  end

  // most recent match: no other match has a lower rank
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      best_oh[i] = match[i];
      for (int j = 0; j < DEPTH; j++) begin
        if (match[j] && (ranks[j] < ranks[i])) begin
          best_oh[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    best_rank  = '0;
    best_value = '0;
    lru_key    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      best_rank  = best_rank  | (ranks[i]  & {RW{best_oh[i]}});
      best_value = best_value | (values[i] & {VALUE_WIDTH{best_oh[i]}});
      lru_key    = lru_key    | (keys[i]   & {KEY_WIDTH{lru_oh[i]}});
    end
  end

  always_comb begin
    upd         = '0;
    slot_oh     = '0;
    limit       = '0;
    hit         = 1'b0;
    found_value = '0;
    evicted     = 1'b0;
    evicted_key = '0;
    if (action == ACT_INSERT) begin
      upd.apply     = 1'b1;
      upd.write_kv  = 1'b1;
      upd.inc_count = !full;
      slot_oh       = full ? lru_oh : ins_oh;
      limit         = full ? lru_rank : count;
      evicted       = full;
      evicted_key   = full ? lru_key : '0;
    end else begin
      upd.apply   = |match;
      slot_oh     = best_oh;
      limit       = CW'(best_rank);
      hit         = |match;
      found_value = best_value;
    end
  end

endmodule

// ===== rtl/lct_entries.sv =====
// entry store: key, value and recency rank registers plus the entry count
// depends on lct_pkg
`timescale 1ns / 1ps

module lct_entries import lct_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  lct_upd_t               upd,
  input  logic [DEPTH-1:0]       slot_oh,
  input  logic [CW-1:0]          limit,
  input  logic [KEY_WIDTH-1:0]   key,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic [CW-1:0]          count,
  output logic [KEY_WIDTH-1:0]   keys   [DEPTH],
  output logic [VALUE_WIDTH-1:0] values [DEPTH],
  output logic [RW-1:0]          ranks  [DEPTH]
);

  logic [KEY_WIDTH-1:0]   keys_r   [DEPTH];
  logic [VALUE_WIDTH-1:0] values_r [DEPTH];
  logic [RW-1:0]          rank_r   [DEPTH];
  logic [CW-1:0]          count_r;

  // payload words carry no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (en && upd.apply && upd.write_kv && slot_oh[i]) begin
        keys_r[i]   <= key;
        values_r[i] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= '0;
      end
    end else if (en && upd.apply) begin
      count_r <= count_r + CW'(upd.inc_count);
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_oh[i]) begin
          rank_r[i] <= '0;
        end else if ((CW'(i) < count_r) && (CW'(rank_r[i]) < limit)) begin
          rank_r[i] <= rank_r[i] + RW'(1);
        end
      end
    end
  end

  assign count  = count_r;
  assign keys   = keys_r;
  assign values = values_r;
  assign ranks  = rank_r;

endmodule

// ===== rtl/lru_cache_table.sv =====
// lru cache table: from input transfer to result valid an item passes the input register,
// then select and rank update into the result register
// throughput one item per cycle while the result side is not stalled, set by the parallel key compare
// and rank update over the entry registers
// reset clears entry count, ranks and both channel stages, capacity goes to 3;
// keys and values hold no reset and are read only below the entry count
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_cache_table import lct_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_W_DEF,
  parameter int VALUE_WIDTH = VALUE_W_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  lct_in_if.sink            in_ch,
  lct_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------- config
  logic [CAP_W-1:0] cap_r;

  assign pready = 1'b1;

  // word index sits at paddr[2], byte offset bits ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(APB_DW-CAP_W){1'b0}}, cap_r};
    end
  end

  // ---------------------------------------------------------------- input stage
  logic                   stg_v_r;
  logic                   stg_action_r;
  logic [KEY_WIDTH-1:0]   stg_key_r;
  logic [VALUE_WIDTH-1:0] stg_value_r;
  logic                   out_v_r;
  logic                   adv;

  // stage moves on when the result register is free or being drained
  assign adv          = stg_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_action_r <= in_ch.action;
      stg_key_r    <= in_ch.key;
      stg_value_r  <= in_ch.value;
    end
  end

  // ---------------------------------------------------------------- cache core
  lct_upd_t               upd;
  logic [DEPTH-1:0]       slot_oh;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          count;
  logic [KEY_WIDTH-1:0]   keys   [DEPTH];
  logic [VALUE_WIDTH-1:0] values [DEPTH];
  logic [RW-1:0]          ranks  [DEPTH];
  logic                   res_hit;
  logic [VALUE_WIDTH-1:0] res_found;
  logic                   res_evicted;
  logic [KEY_WIDTH-1:0]   res_evkey;
  logic [CW-1:0]          occ_nxt;

  lct_select #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_select (
    .action      (stg_action_r),
    .key         (stg_key_r),
    .capacity    (cap_r),
    .count       (count),
    .keys        (keys),
    .values      (values),
    .ranks       (ranks),
    .upd         (upd),
    .slot_oh     (slot_oh),
    .limit       (limit),
    .hit         (res_hit),
    .found_value (res_found),
    .evicted     (res_evicted),
    .evicted_key (res_evkey)
  );

  lct_entries #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_entries (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .upd     (upd),
    .slot_oh (slot_oh),
    .limit   (limit),
    .key     (stg_key_r),
    .value   (stg_value_r),
    .count   (count),
    .keys    (keys),
    .values  (values),
    .ranks   (ranks)
  );

  // occupancy after this item
  assign occ_nxt = count + CW'(upd.inc_count);

  // ---------------------------------------------------------------- result register
  logic                   out_hit_r;
  logic [VALUE_WIDTH-1:0] out_found_r;
  logic                   out_evicted_r;
  logic [KEY_WIDTH-1:0]   out_evkey_r;
  logic [CW-1:0]          out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r     <= res_hit;
      out_found_r   <= res_found;
      out_evicted_r <= res_evicted;
      out_evkey_r   <= res_evkey;
      out_occ_r     <= occ_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.found_value = out_found_r;
  assign out_ch.evicted     = out_evicted_r;
  assign out_ch.evicted_key = out_evkey_r;
  assign out_ch.occupancy   = out_occ_r;

  // ---------------------------------------------------------------- checks
  // an insert either grows the table or evicts, never both or neither
  `ASSERT_IMP(a_ins_evict_xor_grow, clk, rst_n, adv && (stg_action_r == ACT_INSERT), res_evicted != upd.inc_count, "insert must either evict or grow")
  // at most one slot is touched per transfer
  `ASSERT_IMP(a_slot_onehot, clk, rst_n, adv && upd.apply, $onehot(slot_oh), "slot select not one-hot")
  // entry count stays within the table
  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count <= CW'(DEPTH), "entry count above depth")

endmodule

// ===== sim/tb_lru_cache_table.sv =====
// self-checking testbench for lru_cache_table: random and directed inserts and lookups
// depends on lct_pkg and the lct_in_if / lct_out_if channel interfaces from rtl
`timescale 1ns / 1ps

module tb_lru_cache_table;
  import lct_pkg::*;

  localparam int OCC_W = $clog2(DEPTH_DEF + 1);
  localparam int KEY_POOL_N = 6;
  localparam int STALL_LIMIT = 5000;     // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 4;      // wait before the final check, a margin past the input and result registers
  localparam int PHASE_ITEMS = 125;
  localparam logic [APB_AW-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic                   action;
    logic [KEY_W_DEF-1:0]   key;
    logic [VALUE_W_DEF-1:0] value;
  } cache_req_t;

  typedef struct packed {
    logic                   hit;
    logic [VALUE_W_DEF-1:0] found_value;
    logic                   evicted;
    logic [KEY_W_DEF-1:0]   evicted_key;
    logic [OCC_W-1:0]       occupancy;
  } cache_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // configuration port
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lct_in_if  in_ch ();
  lct_out_if out_ch ();

  lru_cache_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // requests waiting to be driven and results the block still owes us
  cache_req_t    pending_requests[$];
  cache_result_t due_results[$];

  int unsigned requests_queued = 0;   // pushed by the stimulus process
  int unsigned requests_taken = 0;    // counted at input transfers
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        in_taken = 1'b0;       // input transfer happened at the last rising edge

  logic [KEY_W_DEF-1:0] key_pool[KEY_POOL_N];

  // ---------------------------------------------------------------------------
  // cache predictor: own copy of the entry store, ranks and capacity register
  // rank 0 is the most recent entry; valid slots are 0 .. live_count-1
  // ---------------------------------------------------------------------------
  logic [KEY_W_DEF-1:0]   slot_key[DEPTH_DEF];
  logic [VALUE_W_DEF-1:0] slot_val[DEPTH_DEF];
  int unsigned            slot_rank[DEPTH_DEF];
  int unsigned            live_count = 0;
  logic [CAP_W-1:0]       cap_setting = CAP_RESET;

  function automatic cache_result_t cache_apply(input cache_req_t req);
    cache_result_t r;
    int unsigned   held;
    int unsigned   slot;
    int unsigned   oldest;
    int unsigned   best_rank;
    bit            found;
    int            i;
    r = '0;
    // zero capacity acts as one, anything past the table size saturates
    held = cap_setting;
    if (held == 0) held = 1;
    if (held > DEPTH_DEF) held = DEPTH_DEF;
    if (req.action == ACT_INSERT) begin
      if (live_count >= held && live_count > 0) begin
        // full (or capacity lowered below occupancy): replace the least recent entry
        oldest = live_count - 1;
        slot = 0;
        for (i = 0; i < live_count; i++)
          if (slot_rank[i] == oldest) slot = i;
        r.evicted = 1'b1;
        r.evicted_key = slot_key[slot];
        for (i = 0; i < live_count; i++)
          if (slot_rank[i] < oldest) slot_rank[i]++;
      end else begin
        slot = live_count;
        for (i = 0; i < live_count; i++)
          slot_rank[i]++;
        live_count++;
      end
      slot_key[slot] = req.key;
      slot_val[slot] = req.value;
      slot_rank[slot] = 0;
    end else begin
      // duplicates allowed, the most recent match wins
      found = 1'b0;
      slot = 0;
      best_rank = 0;
      for (i = 0; i < live_count; i++) begin
        if (slot_key[i] == req.key && (!found || slot_rank[i] < best_rank)) begin
          found = 1'b1;
          slot = i;
          best_rank = slot_rank[i];
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.found_value = slot_val[slot];
        // move to front: everything more recent than the match ages by one
        for (i = 0; i < live_count; i++)
          if (slot_rank[i] < best_rank) slot_rank[i]++;
        slot_rank[slot] = 0;
      end
    end
    r.occupancy = OCC_W'(live_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: changes on the falling edge, holds a request until its transfer
  // ---------------------------------------------------------------------------
  cache_req_t drive_req;

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        drive_req = pending_requests.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= drive_req.action;
        in_ch.key    <= drive_req.key;
        in_ch.value  <= drive_req.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    // result side back-pressure
    out_ch.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts at input transfers, checks at result transfers, watchdog
  // ---------------------------------------------------------------------------
  cache_result_t got;
  cache_result_t want;

  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.hit         = out_ch.hit;
        got.found_value = out_ch.found_value;
        got.evicted     = out_ch.evicted;
        got.evicted_key = out_ch.evicted_key;
        got.occupancy   = out_ch.occupancy;
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result transfer with nothing outstanding: hit=%0b value=%h",
                     $realtime, got.hit, got.found_value);
        end else begin
          want = due_results.pop_front();
          if (got.hit !== want.hit || got.found_value !== want.found_value ||
              got.evicted !== want.evicted || got.evicted_key !== want.evicted_key ||
              got.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected hit=%0b value=%h evicted=%0b ev_key=%h occ=%0d",
                       $realtime, want.hit, want.found_value, want.evicted,
                       want.evicted_key, want.occupancy);
              $display("%0t:   actual hit=%0b value=%h evicted=%0b ev_key=%h occ=%0d",
                       $realtime, got.hit, got.found_value, got.evicted,
                       got.evicted_key, got.occupancy);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(cache_apply({in_ch.action, in_ch.key, in_ch.value}));
        requests_taken++;
      end
      // watchdog on cycles without any transfer
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
          $display("tb_lru_cache_table NOT OK");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic act, input logic [KEY_W_DEF-1:0] k,
                               input logic [VALUE_W_DEF-1:0] v);
    pending_requests.push_back({act, k, v});
    requests_queued++;
  endtask

  // stimulus holds off until every queued request is taken and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (!(requests_taken == requests_queued && due_results.size() == 0));
    @(posedge clk);
  endtask

  // apb write: setup then access, register updates at the access edge
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= ($urandom & ~APB_DW'((1 << CAP_W) - 1)) | APB_DW'(cap);  // junk above the field
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    cap_setting = cap;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a small pool of keys so lookups hit and duplicates pile up
  task automatic queue_random_request();
    logic [KEY_W_DEF-1:0] k;
    int unsigned          pick;
    pick = $urandom_range(99);
    if (pick < 80) k = key_pool[$urandom_range(KEY_POOL_N - 1)];
    else if (pick < 85) k = '0;
    else if (pick < 90) k = '1;
    else k = $urandom;
    queue_request(($urandom_range(99) < 50) ? ACT_LOOKUP : ACT_INSERT, k, $urandom);
  endtask

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int n;
    write_capacity(cap);
    for (n = 0; n < KEY_POOL_N; n++)
      key_pool[n] = $urandom;
    sender_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (n = 0; n < PHASE_ITEMS; n++)
      queue_random_request();
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] phase_cap[10] = '{4'd8, 4'd1, 4'd15, 4'd2, 4'd0,
                                      4'd5, 4'd3, 4'd7, 4'd4, 4'd6};
  int unsigned      phase_idle[4] = '{0, 69, 0, 8};
  int unsigned      phase_stall[4] = '{0, 0, 69, 8};

  initial begin
    int p;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_INSERT;
    in_ch.key    = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty lookup, extremes, duplicates, eviction
    queue_request(ACT_LOOKUP, '0, '1);
    queue_request(ACT_INSERT, '0, '0);
    queue_request(ACT_INSERT, '1, '1);
    queue_request(ACT_LOOKUP, '1, '0);
    queue_request(ACT_INSERT, '0, 32'ha5a5_a5a5);
    queue_request(ACT_LOOKUP, '0, '0);
    queue_request(ACT_INSERT, 32'h1234_5678, 32'h5a5a_5a5a);
    queue_request(ACT_LOOKUP, '1, '0);
    wait_idle();

    // capacity one, below the current occupancy: every insert evicts the least recent entry
    write_capacity(4'd1);
    queue_request(ACT_INSERT, 32'h0000_0001, 32'h0000_00aa);
    queue_request(ACT_INSERT, 32'h8000_0000, 32'h0000_00bb);
    queue_request(ACT_LOOKUP, 32'h8000_0000, '0);
    wait_idle();

    // zero behaves as one
    write_capacity(4'd0);
    queue_request(ACT_INSERT, 32'hdead_beef, 32'hcafe_f00d);
    queue_request(ACT_LOOKUP, 32'hdead_beef, '0);
    wait_idle();

    // above the table size saturates: the table fills to eight entries, then further inserts evict
    write_capacity(4'd15);
    for (p = 0; p < DEPTH_DEF + 1; p++)
      queue_request(ACT_INSERT, 32'h100 + p, 32'h200 + p);
    wait_idle();

    // lowered below occupancy: insert evicts one, occupancy holds at eight
    write_capacity(4'd2);
    queue_request(ACT_INSERT, 32'h0f0f_0f0f, 32'hf0f0_f0f0);
    queue_request(ACT_LOOKUP, 32'h103, '0);
    wait_idle();

    // random phases cycling through the idling patterns
    for (p = 0; p < 10; p++)
      run_random_phase(phase_cap[p], phase_idle[p % 4], phase_stall[p % 4]);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("tb_lru_cache_table OK");
    end else begin
      $display("tb_lru_cache_table NOT OK");
    end
    $finish;
  end

endmodule

// ===== lru_cache_table.f =====
+incdir+rtl
rtl/lct_pkg.sv
rtl/lct_if.sv
rtl/lct_select.sv
rtl/lct_entries.sv
rtl/lru_cache_table.sv
sim/tb_lru_cache_table.sv
